/* rtl/core/bdh_pkg.sv */
package bdh_pkg;

  localparam int unsigned TimeW = 16;

  // Codes reported on machine_state.
  localparam logic [2:0] CODE_IDLE         = 3'd0;
  localparam logic [2:0] CODE_PRESS        = 3'd1;
  localparam logic [2:0] CODE_WAIT_HOLD    = 3'd2;
  localparam logic [2:0] CODE_HOLD         = 3'd3;
  localparam logic [2:0] CODE_WAIT_RELEASE = 3'd4;

  // Configuration register indexes.
  localparam logic REG_DEBOUNCE_MS = 1'b0;
  localparam logic REG_HOLD_MS     = 1'b1;

  localparam logic [TimeW-1:0] DEBOUNCE_MS_RESET = 16'd10;
  localparam logic [TimeW-1:0] HOLD_MS_RESET     = 16'd1000;

  typedef enum logic [4:0] {
    S_IDLE         = 5'b00001,
    S_PRESS        = 5'b00010,
    S_WAIT_HOLD    = 5'b00100,
    S_HOLD         = 5'b01000,
    S_WAIT_RELEASE = 5'b10000
  } state_e;

  // Per-transaction control handed to the filter and the state machine.
  typedef struct packed {
    logic en;       // a transaction is being processed this cycle
    logic restart;  // the transaction is a restart request
  } step_t;

  // Result of the state machine for one transaction.
  typedef struct packed {
    logic [2:0] code;
    logic       press;
    logic       hold;
  } fsm_res_t;

  // Adds two millisecond counts and clamps the sum at the maximum.
  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

  function automatic logic [2:0] state_code(input state_e s);
    logic [2:0] c;
    case (s)
      S_IDLE:         c = CODE_IDLE;
      S_PRESS:        c = CODE_PRESS;
      S_WAIT_HOLD:    c = CODE_WAIT_HOLD;
      S_HOLD:         c = CODE_HOLD;
      S_WAIT_RELEASE: c = CODE_WAIT_RELEASE;
      default:        c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/bdh_filter.sv */
// Debounce filter: a raw level becomes the stable level once it has
// persisted for the debounce time.
module bdh_filter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bdh_pkg::step_t            step_i,
  input  logic                      pressed_i,
  input  logic [bdh_pkg::TimeW-1:0] elapsed_ms_i,
  input  logic [bdh_pkg::TimeW-1:0] debounce_ms_i,
  output logic                      level_o
);

  logic                      last_raw_q, last_raw_d;
  logic                      level_q, level_d;
  logic [bdh_pkg::TimeW-1:0] timer_q, timer_d;
  logic [bdh_pkg::TimeW-1:0] timer_sum;

  assign timer_sum = bdh_pkg::sat_add(timer_q, elapsed_ms_i);

  always_comb begin
    last_raw_d = last_raw_q;
    level_d    = level_q;
    timer_d    = timer_q;
    if (step_i.en && !step_i.restart) begin
      if (pressed_i != last_raw_q) begin
        last_raw_d = pressed_i;
        timer_d    = '0;
      end else if (level_q != pressed_i) begin
        if (timer_sum >= debounce_ms_i) begin
          level_d = pressed_i;
          timer_d = '0;
        end else begin
          timer_d = timer_sum;
        end
      end
    end
  end

  // The state machine sees the level as it stands after this transaction.
  assign level_o = level_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b0;
      level_q    <= 1'b0;
      timer_q    <= '0;
    end else begin
      last_raw_q <= last_raw_d;
      level_q    <= level_d;
      timer_q    <= timer_d;
    end
  end

endmodule

/* rtl/core/bdh_fsm.sv */
// Press and hold state machine with its saturating hold timer.
module bdh_fsm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bdh_pkg::step_t            step_i,
  input  logic                      level_i,
  input  logic [bdh_pkg::TimeW-1:0] elapsed_ms_i,
  input  logic [bdh_pkg::TimeW-1:0] hold_ms_i,
  output bdh_pkg::fsm_res_t         res_o
);

  bdh_pkg::state_e           state_q, state_d;
  logic [bdh_pkg::TimeW-1:0] timer_q, timer_d;
  logic [bdh_pkg::TimeW-1:0] timer_sum;

  assign timer_sum = bdh_pkg::sat_add(timer_q, elapsed_ms_i);

  always_comb begin
    state_d = state_q;
    timer_d = timer_q;
    if (step_i.en) begin
      if (step_i.restart) begin
        state_d = bdh_pkg::S_IDLE;
        timer_d = '0;
      end else begin
        timer_d = timer_sum;
        case (state_q)
          bdh_pkg::S_IDLE: begin
            if (level_i) state_d = bdh_pkg::S_PRESS;
          end
          bdh_pkg::S_PRESS: begin
            state_d = bdh_pkg::S_WAIT_HOLD;
            timer_d = '0;
          end
          bdh_pkg::S_WAIT_HOLD: begin
            if (!level_i) begin
              state_d = bdh_pkg::S_IDLE;
            end else if (timer_sum >= hold_ms_i) begin
              state_d = bdh_pkg::S_HOLD;
              timer_d = '0;
            end
          end
          bdh_pkg::S_HOLD: begin
            state_d = bdh_pkg::S_WAIT_RELEASE;
          end
          bdh_pkg::S_WAIT_RELEASE: begin
            if (!level_i) state_d = bdh_pkg::S_IDLE;
          end
          default: begin
            state_d = bdh_pkg::S_IDLE;
          end
        endcase
      end
    end
  end

  assign res_o.code  = bdh_pkg::state_code(state_d);
  assign res_o.press = (state_d == bdh_pkg::S_PRESS);
  assign res_o.hold  = (state_d == bdh_pkg::S_HOLD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdh_pkg::S_IDLE;
      timer_q <= '0;
    end else begin
      state_q <= state_d;
      timer_q <= timer_d;
    end
  end

endmodule

/* rtl/core/button_debounce_hold_detector.sv */
// Channel | Direction | Handshake                 | Payload
// --------+-----------+---------------------------+---------------------------------
// tick    | in        | in_valid_i / in_ready_o   | mode_i, pressed_i, elapsed_ms_i
// result  | out       | out_valid_o / out_ready_i | machine_state_o, press_event_o,
//         |           |                           | hold_event_o, stable_level_o
// config  | in        | cfg_we_i (always taken)   | cfg_index_i, cfg_wdata_i
//
// Each accepted transaction is held in an input register and is processed once the
// output register is empty or being emptied, when its result is loaded into it; one
// transaction is taken every cycle while the output is drained.
// The output register is the only stall point: while it holds an untaken result,
// the input register keeps its transaction and in_ready_o drops only if both are
// full. Reset clears the debounce and hold state, empties both registers and
// loads the configuration registers with their defaults.
module button_debounce_hold_detector (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Tick channel.
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic                      pressed_i,
  input  logic [bdh_pkg::TimeW-1:0] elapsed_ms_i,
  // Result channel.
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                machine_state_o,
  output logic                      press_event_o,
  output logic                      hold_event_o,
  output logic                      stable_level_o,
  // Configuration write port.
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [bdh_pkg::TimeW-1:0] cfg_wdata_i
);

  // Configuration registers.
  logic [bdh_pkg::TimeW-1:0] debounce_ms_q;
  logic [bdh_pkg::TimeW-1:0] hold_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms_q <= bdh_pkg::DEBOUNCE_MS_RESET;
      hold_ms_q     <= bdh_pkg::HOLD_MS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bdh_pkg::REG_DEBOUNCE_MS: debounce_ms_q <= cfg_wdata_i;
        bdh_pkg::REG_HOLD_MS:     hold_ms_q     <= cfg_wdata_i;
        default:                  ;
      endcase
    end
  end

  // Input register. The transaction it holds moves on when the output
  // register is empty or is being emptied in this cycle.
  logic                      in_valid_q;
  logic                      mode_q;
  logic                      pressed_q;
  logic [bdh_pkg::TimeW-1:0] elapsed_q;
  logic                      advance;

  assign advance    = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // The payload needs no reset; it is only looked at behind in_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mode_q    <= mode_i;
      pressed_q <= pressed_i;
      elapsed_q <= elapsed_ms_i;
    end
  end

  // Both state holders update only in the cycle that a transaction advances,
  // so a stalled output never lets the state run ahead of the results.
  bdh_pkg::step_t    step;
  logic              level;
  bdh_pkg::fsm_res_t fsm_res;

  assign step.en      = advance;
  assign step.restart = mode_q;

  bdh_filter u_filter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .pressed_i     (pressed_q),
    .elapsed_ms_i  (elapsed_q),
    .debounce_ms_i (debounce_ms_q),
    .level_o       (level)
  );

  bdh_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .level_i      (level),
    .elapsed_ms_i (elapsed_q),
    .hold_ms_i    (hold_ms_q),
    .res_o        (fsm_res)
  );

  // Output register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      machine_state_o <= fsm_res.code;
      press_event_o   <= fsm_res.press;
      hold_event_o    <= fsm_res.hold;
      stable_level_o  <= level;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/bdh_checker.sv */
module bdh_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] machine_state_o,
  input logic       press_event_o,
  input logic       hold_event_o,
  input logic       stable_level_o
);

  // A result that is not taken stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(machine_state_o) &&
      $stable(press_event_o) && $stable(hold_event_o) && $stable(stable_level_o))
    else $error("result changed while stalled");

  // The input side only stalls when a result is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> press_event_o == (machine_state_o == bdh_pkg::CODE_PRESS))
    else $error("press event disagrees with state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hold_event_o == (machine_state_o == bdh_pkg::CODE_HOLD))
    else $error("hold event disagrees with state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> machine_state_o <= bdh_pkg::CODE_WAIT_RELEASE)
    else $error("state code out of range");

endmodule

bind button_debounce_hold_detector bdh_checker u_bdh_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .machine_state_o (machine_state_o),
  .press_event_o   (press_event_o),
  .hold_event_o    (hold_event_o),
  .stable_level_o  (stable_level_o)
);

/* sim/bdh_checker.sv */
module bdh_tb_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic                      mode_i,
  input  logic                      pressed_i,
  input  logic [bdh_pkg::TimeW-1:0] elapsed_ms_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [2:0]                machine_state_i,
  input  logic                      press_event_i,
  input  logic                      hold_event_i,
  input  logic                      stable_level_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [bdh_pkg::TimeW-1:0] cfg_wdata_i,
  output int                        errors_o,
  output int                        pending_o,
  output int                        presses_o,
  output int                        holds_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] code;
    logic       press;
    logic       hold;
    logic       level;
  } btn_report_t;

  // Own copy of the registers and of the debounce and hold state.
  logic [bdh_pkg::TimeW-1:0] debounce_cfg;
  logic [bdh_pkg::TimeW-1:0] hold_cfg;
  logic [2:0]                fsm_code;
  logic [bdh_pkg::TimeW-1:0] hold_acc;
  logic [bdh_pkg::TimeW-1:0] settle_acc;
  logic                      raw_seen;
  logic                      level_now;

  btn_report_t reports_due[$];

  function automatic logic [bdh_pkg::TimeW-1:0] clamp_add(
      input logic [bdh_pkg::TimeW-1:0] a,
      input logic [bdh_pkg::TimeW-1:0] b);
    logic [bdh_pkg::TimeW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum[bdh_pkg::TimeW]) begin
      return {bdh_pkg::TimeW{1'b1}};
    end
    return sum[bdh_pkg::TimeW-1:0];
  endfunction

  // Advances the button state by one transaction and returns what it reports.
  task automatic advance_button(input logic restart, input logic level,
                                input logic [bdh_pkg::TimeW-1:0] dt,
                                output btn_report_t rep);
    if (restart) begin
      fsm_code = bdh_pkg::CODE_IDLE;
      hold_acc = '0;
    end else begin
      if (level != raw_seen) begin
        raw_seen   = level;
        settle_acc = '0;
      end else if (level_now != level) begin
        settle_acc = clamp_add(settle_acc, dt);
        if (settle_acc >= debounce_cfg) begin
          level_now  = level;
          settle_acc = '0;
        end
      end
      hold_acc = clamp_add(hold_acc, dt);
      case (fsm_code)
        bdh_pkg::CODE_IDLE: if (level_now) fsm_code = bdh_pkg::CODE_PRESS;
        bdh_pkg::CODE_PRESS: begin
          fsm_code = bdh_pkg::CODE_WAIT_HOLD;
          hold_acc = '0;
        end
        bdh_pkg::CODE_WAIT_HOLD: begin
          if (!level_now) begin
            fsm_code = bdh_pkg::CODE_IDLE;
          end else if (hold_acc >= hold_cfg) begin
            fsm_code = bdh_pkg::CODE_HOLD;
            hold_acc = '0;
          end
        end
        bdh_pkg::CODE_HOLD: fsm_code = bdh_pkg::CODE_WAIT_RELEASE;
        bdh_pkg::CODE_WAIT_RELEASE: if (!level_now) fsm_code = bdh_pkg::CODE_IDLE;
        default: fsm_code = bdh_pkg::CODE_IDLE;
      endcase
    end
    rep.code  = fsm_code;
    rep.press = (fsm_code == bdh_pkg::CODE_PRESS);
    rep.hold  = (fsm_code == bdh_pkg::CODE_HOLD);
    rep.level = level_now;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    btn_report_t want;
    btn_report_t got;
    if (!rst_ni) begin
      debounce_cfg = bdh_pkg::DEBOUNCE_MS_RESET;
      hold_cfg     = bdh_pkg::HOLD_MS_RESET;
      fsm_code     = bdh_pkg::CODE_IDLE;
      hold_acc     = '0;
      settle_acc   = '0;
      raw_seen     = 1'b0;
      level_now    = 1'b0;
      reports_due.delete();
      errors_o     = 0;
      presses_o    = 0;
      holds_o      = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == bdh_pkg::REG_DEBOUNCE_MS) begin
          debounce_cfg = cfg_wdata_i;
        end else if (cfg_index_i == bdh_pkg::REG_HOLD_MS) begin
          hold_cfg = cfg_wdata_i;
        end
      end

      if (out_valid_i && out_ready_i) begin
        got.code  = machine_state_i;
        got.press = press_event_i;
        got.hold  = hold_event_i;
        got.level = stable_level_i;
        if (reports_due.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) begin
            $display("%0t: unexpected result: state %0d press %0b hold %0b level %0b",
                     $time, got.code, got.press, got.hold, got.level);
          end
        end else begin
          want = reports_due.pop_front();
          if (got.code !== want.code || got.press !== want.press ||
              got.hold !== want.hold || got.level !== want.level) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("%0t: result mismatch: expected state %0d press %0b hold %0b level %0b",
                       $time, want.code, want.press, want.hold, want.level);
              $display("%0t:                    actual state %0d press %0b hold %0b level %0b",
                       $time, got.code, got.press, got.hold, got.level);
            end
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        advance_button(mode_i, pressed_i, elapsed_ms_i, want);
        reports_due.push_back(want);
        if (want.press) presses_o++;
        if (want.hold) holds_o++;
      end
    end
    pending_o = reports_due.size();
  end

endmodule

/* sim/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous ceiling on the whole run; a correct run needs a small fraction of it.
  localparam int unsigned CycleLimit    = 400000;
  // How long the result side refuses transactions during the back-pressure phase.
  localparam int unsigned HoldoffCycles = 120;
  localparam int unsigned PhaseTicks    = 140;
  localparam int unsigned NumPhases     = 10;

  // Every input of the block has a known value from time zero.
  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_valid   = 1'b0;
  logic                      in_ready;
  logic                      mode       = 1'b0;
  logic                      pressed    = 1'b0;
  logic [bdh_pkg::TimeW-1:0] elapsed_ms = '0;
  logic                      out_valid;
  logic                      out_ready  = 1'b0;
  logic [2:0]                machine_state;
  logic                      press_event;
  logic                      hold_event;
  logic                      stable_level;
  logic                      cfg_we     = 1'b0;
  logic                      cfg_index  = bdh_pkg::REG_DEBOUNCE_MS;
  logic [bdh_pkg::TimeW-1:0] cfg_wdata  = '0;

  int errors;
  int pending;
  int presses;
  int holds;

  // Chance, in percent, that either side idles in a given cycle.
  int unsigned idle_pct      = 27;
  int unsigned holdoff_asked = 0;
  int unsigned holdoff_done  = 0;
  int unsigned holdoff_left  = 0;
  int unsigned cycle_count   = 0;
  int unsigned input_stalls  = 0;
  int unsigned ticks_sent    = 0;
  int unsigned restarts_sent = 0;
  int unsigned settings_used = 1;

  always #5 clk = ~clk;

  button_debounce_hold_detector dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .mode_i          (mode),
    .pressed_i       (pressed),
    .elapsed_ms_i    (elapsed_ms),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .machine_state_o (machine_state),
    .press_event_o   (press_event),
    .hold_event_o    (hold_event),
    .stable_level_o  (stable_level),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata)
  );

  // The checker sees exactly what the block sees and predicts every result.
  bdh_tb_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .mode_i          (mode),
    .pressed_i       (pressed),
    .elapsed_ms_i    (elapsed_ms),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .machine_state_i (machine_state),
    .press_event_i   (press_event),
    .hold_event_i    (hold_event),
    .stable_level_i  (stable_level),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .errors_o        (errors),
    .pending_o       (pending),
    .presses_o       (presses),
    .holds_o         (holds)
  );

  // Watchdog: a hung handshake must not leave the run going for ever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[button_debounce_hold_detector] ERROR");
      $finish;
    end
  end

  // Counts the cycles in which a tick transaction is offered but refused, which
  // shows that the back-pressure phase really filled the block.
  always @(posedge clk) begin
    if (in_valid && !in_ready) begin
      input_stalls <= input_stalls + 1;
    end
  end

  // Result side. Normally it refuses at random; when the stimulus asks for a
  // hold-off it refuses for a long, counted stretch regardless of the sender.
  always @(posedge clk) begin
    if (holdoff_left > 0) begin
      out_ready    <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_asked != holdoff_done) begin
      out_ready    <= 1'b0;
      holdoff_left <= HoldoffCycles;
      holdoff_done <= holdoff_done + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Offers one tick transaction and returns at the edge that accepts it. Valid is
  // left high so that a following transaction can go out in the very next cycle;
  // it is only lowered when an idle cycle is chosen or the sender stops.
  task automatic send_tick(input logic restart, input logic level,
                           input logic [bdh_pkg::TimeW-1:0] dt);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= restart;
    pressed    <= level;
    elapsed_ms <= dt;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
    if (restart) restarts_sent++;
  endtask

  // Stops offering and waits until every predicted result has been taken, so the
  // block is empty. The first edge makes sure the checker has seen the last
  // accepted transaction before its count is trusted.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Both registers are written on consecutive cycles with the block idle.
  task automatic configure(input logic [bdh_pkg::TimeW-1:0] debounce_val,
                           input logic [bdh_pkg::TimeW-1:0] hold_val);
    cfg_we    <= 1'b1;
    cfg_index <= bdh_pkg::REG_DEBOUNCE_MS;
    cfg_wdata <= debounce_val;
    @(posedge clk);
    cfg_index <= bdh_pkg::REG_HOLD_MS;
    cfg_wdata <= hold_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Time steps are mostly scaled to the current setting so that debounce and
  // hold thresholds are actually crossed; now and then a step is full range.
  function automatic logic [bdh_pkg::TimeW-1:0] pick_dt(input int unsigned span);
    if ($urandom_range(19) == 0) begin
      return 16'($urandom);
    end
    return 16'($urandom_range(span));
  endfunction

  // Random stimulus for one setting. Most of it is steady runs of one raw level,
  // long enough to debounce and often to reach a hold; the rest is contact
  // bounce (short alternating samples) and restart requests with random fields.
  task automatic run_phase(input int unsigned count, input int unsigned span);
    int unsigned left;
    int unsigned pick;
    int unsigned run;
    int unsigned k;
    logic        level;
    left  = count;
    level = 1'($urandom_range(1));
    while (left > 0) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_tick(1'b1, 1'($urandom_range(1)), 16'($urandom));
        left--;
      end else if (pick < 14) begin
        run = $urandom_range(6, 2);
        for (k = 0; k < run && left > 0; k++) begin
          send_tick(1'b0, level ^ k[0], pick_dt(span / 4 + 1));
          left--;
        end
      end else begin
        level = ~level;
        run   = $urandom_range(12, 1);
        for (k = 0; k < run && left > 0; k++) begin
          send_tick(1'b0, level, pick_dt(span));
          left--;
        end
      end
    end
  endtask

  initial begin : stimulus
    int unsigned               ph;
    int unsigned               span;
    logic [bdh_pkg::TimeW-1:0] debounce_val;
    logic [bdh_pkg::TimeW-1:0] hold_val;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset settings (debounce 10 ms, hold 1000 ms). A raw change
    // only restarts the debounce timer; the next equal sample is accepted, then
    // press, wait for hold, hold exactly at the threshold and wait for release.
    // A restart with every other field at its maximum must leave the stable level
    // alone, and a release from the wait-hold state goes straight back to idle.
    send_tick(1'b0, 1'b0, 16'd0);
    send_tick(1'b0, 1'b1, 16'hFFFF);
    send_tick(1'b0, 1'b1, 16'hFFFF);
    send_tick(1'b0, 1'b1, 16'd0);
    send_tick(1'b0, 1'b1, 16'd999);
    send_tick(1'b0, 1'b1, 16'd1);
    send_tick(1'b0, 1'b1, 16'hFFFF);
    send_tick(1'b1, 1'b1, 16'hFFFF);
    send_tick(1'b0, 1'b1, 16'd0);
    send_tick(1'b0, 1'b0, 16'hFFFF);
    send_tick(1'b0, 1'b0, 16'hFFFF);
    wait_drain();

    // Zero debounce still needs one repeated sample; zero hold fires on the
    // first wait-hold tick that is still pressed.
    configure(16'd0, 16'd0);
    send_tick(1'b0, 1'b1, 16'd0);
    send_tick(1'b0, 1'b1, 16'd0);
    send_tick(1'b0, 1'b1, 16'd0);
    send_tick(1'b0, 1'b1, 16'd0);
    send_tick(1'b0, 1'b1, 16'd0);
    send_tick(1'b1, 1'b0, 16'd0);
    send_tick(1'b0, 1'b0, 16'd0);
    wait_drain();

    // Largest thresholds: the debounce accumulator has to saturate at its maximum
    // rather than wrap for the debounce to complete; the hold then fires on a full step.
    configure(16'hFFFF, 16'hFFFF);
    send_tick(1'b0, 1'b0, 16'hFFFF);
    send_tick(1'b0, 1'b1, 16'h8000);
    send_tick(1'b0, 1'b1, 16'h8000);
    send_tick(1'b0, 1'b1, 16'h8000);
    send_tick(1'b0, 1'b1, 16'hFFFF);
    send_tick(1'b0, 1'b1, 16'hFFFF);
    send_tick(1'b0, 1'b1, 16'hFFFF);

    // Random part: one setting per phase, the extremes first.
    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          debounce_val = 16'd0;
          hold_val     = 16'd0;
        end
        1: begin
          debounce_val = 16'hFFFF;
          hold_val     = 16'hFFFF;
        end
        2: begin
          debounce_val = 16'd0;
          hold_val     = 16'hFFFF;
        end
        3: begin
          debounce_val = 16'hFFFF;
          hold_val     = 16'd0;
        end
        9: begin
          debounce_val = 16'($urandom);
          hold_val     = 16'($urandom);
        end
        default: begin
          debounce_val = 16'($urandom_range(40));
          hold_val     = 16'($urandom_range(300));
        end
      endcase
      span = (int'(debounce_val) + int'(hold_val)) / 3 + 1;
      if (span > 65535) span = 65535;

      // Every phase starts from an empty block: the sender waits for the last
      // result before the registers change.
      wait_drain();
      idle_pct = (ph == 6) ? 0 : 27;
      configure(debounce_val, hold_val);
      if (ph == 4) begin
        holdoff_asked <= holdoff_asked + 1;
      end
      run_phase(PhaseTicks, span);
    end

    wait_drain();
    repeat (8) @(posedge clk);

    $display("Ran %0d tick transactions, %0d of them restarts, under %0d register settings.",
             ticks_sent, restarts_sent, settings_used);
    $display("Saw %0d press and %0d hold events; ticks were held back for %0d cycles.",
             presses, holds, input_stalls);
    if (errors == 0 && pending == 0) begin
      $display("[button_debounce_hold_detector] OK");
    end else begin
      $display("[button_debounce_hold_detector] ERROR");
    end
    $finish;
  end

endmodule
